// ===== rtl/spq_pkg.sv =====
// shared types and constants of the stable priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // number of records the queue holds
  localparam int unsigned CAPACITY = 16;
  // address width of the record store
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // width of the fill count, able to hold CAPACITY itself
  localparam int unsigned FW = $clog2(CAPACITY + 1);

  // status codes of a result
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // operation codes of an input item
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // one stored record, proc_id in the lowest bits
  typedef struct packed {
    logic [15:0] exec_time;
    logic [7:0]  prio;
    logic [15:0] proc_id;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

`default_nettype wire

// ===== rtl/stable_priority_queue.sv =====
// top level of the stable priority queue
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue of process records kept in ascending priority order in a
// single-port-write ram; equal priorities leave in arrival order. One operation is
// taken at a time. An insert walks down from the tail through the ram's registered read
// port, with one read and compare per record it examines, and moves each record of
// higher priority one place back before it writes the new record; a remove reads the
// head, then does one read and write per remaining record to shift it forward; a
// refused operation goes straight to the result stage. The result register is then
// loaded, after which the next item is taken; that load is held for as long as the
// previous result still waits on m_axis_tready. Result fields of an insert, a refused
// insert and a refused remove are zero.
module stable_priority_queue
  import spq_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // proc_id[15:0], prio[23:16], exec_time[39:24]
  input  wire  [0:0]  s_axis_tuser,   // kind[0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_id[15:0], out_prio[23:16],
                                      // out_exec_time[39:24], occupancy[44:40], zero
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_CMP   = 3'd1;
  localparam logic [2:0] S_INS_WNEW  = 3'd2;
  localparam logic [2:0] S_REM_HEAD  = 3'd3;
  localparam logic [2:0] S_REM_SHIFT = 3'd4;
  localparam logic [2:0] S_EMIT      = 3'd5;

  localparam logic [FW-1:0] FILL_FULL = FW'(CAPACITY);

  logic [2:0]    state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] idx_q, idx_d;
  rec_t          new_q, new_d;
  rec_t          res_rec_q, res_rec_d;
  logic [1:0]    res_status_q, res_status_d;
  logic          m_valid_q, m_valid_d;
  logic [47:0]   m_data_q, m_data_d;
  logic [1:0]    m_user_q, m_user_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  rec_t          ram_wdata, ram_rdata;
  logic [FW-1:0] fill_m1;
  logic [AW-1:0] last_idx;
  logic [FW+4:0] occ_ext;
  logic          s_xfer, out_free;

  spq_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign fill_m1       = fill_q - FW'(1);
  assign last_idx      = fill_m1[AW-1:0];
  assign occ_ext       = {5'd0, fill_q};

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // sequencer and ram control
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    new_d        = new_q;
    res_rec_d    = res_rec_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q + AW'(1);
    ram_wdata    = new_q;
    ram_re       = 1'b0;
    ram_raddr    = idx_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          new_d        = rec_t'(s_axis_tdata);
          res_rec_d    = '0;
          res_status_d = ST_OK;
          if (s_axis_tuser[0] == OP_INSERT) begin
            if (fill_q == FILL_FULL) begin
              res_status_d = ST_FULL;
              state_d      = S_EMIT;
            end else if (fill_q == '0) begin
              state_d = S_INS_WNEW;
            end else begin
              // start at the tail and walk toward the head
              idx_d     = last_idx;
              ram_re    = 1'b1;
              ram_raddr = last_idx;
              state_d   = S_INS_CMP;
            end
          end else begin
            if (fill_q == '0) begin
              res_status_d = ST_EMPTY;
              state_d      = S_EMIT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = S_REM_HEAD;
            end
          end
        end
      end

      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q + AW'(1);
        if (ram_rdata.prio > new_q.prio) begin
          // stored record moves one place back
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = S_INS_WNEW;
          end else begin
            idx_d     = idx_q - AW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q - AW'(1);
          end
        end else begin
          // new record goes right after an equal or lower priority
          ram_wdata = new_q;
          fill_d    = fill_q + FW'(1);
          state_d   = S_EMIT;
        end
      end

      S_INS_WNEW: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_q;
        fill_d    = fill_q + FW'(1);
        state_d   = S_EMIT;
      end

      S_REM_HEAD: begin
        res_rec_d = ram_rdata;
        if (fill_q == FW'(1)) begin
          fill_d  = fill_m1;
          state_d = S_EMIT;
        end else begin
          idx_d     = AW'(1);
          ram_re    = 1'b1;
          ram_raddr = AW'(1);
          state_d   = S_REM_SHIFT;
        end
      end

      S_REM_SHIFT: begin
        // shift the record one place toward the head
        ram_we    = 1'b1;
        ram_waddr = idx_q - AW'(1);
        ram_wdata = ram_rdata;
        if (idx_q == last_idx) begin
          fill_d  = fill_m1;
          state_d = S_EMIT;
        end else begin
          idx_d     = idx_q + AW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
        end
      end

      S_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'd0, occ_ext[4:0], REC_W'(res_rec_q)};
          m_user_d  = res_status_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    new_q        <= new_d;
    res_rec_q    <= res_rec_d;
    res_status_q <= res_status_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

endmodule

`default_nettype wire

// ===== rtl/spq_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                             clk_i,
  input  wire                             we_i,
  input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                 wdata_i,
  input  wire                             re_i,
  input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
